// ----- src/tslr_pkg.sv -----
// shared types, constants and the dash pattern lookup of the line rasterizer
// no dependencies
package tslr_pkg;

  localparam int unsigned MAX_PEN = 16;
  localparam int unsigned PATTERN_LEN = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  // input commands
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // decision rules
  localparam logic ALG_MIDPOINT  = 1'b0;
  localparam logic ALG_BRESENHAM = 1'b1;

  // line drawing phase
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  // one pen position handed from the front to the back
  typedef struct packed {
    logic signed [13:0] maj;
    logic signed [13:0] mnr;
    logic [4:0]         w;
    logic               bit_on;
    logic               done;
    logic               steep;
    logic [23:0]        color;
  } job_t;

  // dash pattern bit for a style and a step
  function automatic logic dash_bit(input logic [1:0] style, input logic [3:0] idx);
    logic [15:0] pat;
    case (style)
      2'd1:    pat = 16'b0000_1111_0000_1111;
      2'd2:    pat = 16'b0011_0011_1111_1111;
      2'd3:    pat = 16'b0011_0011_0011_1111;
      default: pat = 16'hFFFF;
    endcase
    return pat[idx];
  endfunction

endpackage

// ----- src/thick_styled_line_rasterizer.sv -----
// top level of the thick styled line rasterizer
// depends on tslr_pkg, tslr_front, tslr_queue, tslr_back
//
// A start transaction latches a line and gives no pixels; each advance
// transaction during a line places one pen position (start cap, body, end
// cap) and gives one pixel write per cycle while out_stall is low, up to 16,
// or a single non-write result when the position is skipped, off-frame or
// clipped away. The span unit sets up a position in a setup state (clip) and
// an address state (start-address multiply), then writes its pixels; the
// front end queues up to two positions ahead of it. Frame size registers are
// written through the cfg port and must only change while the block is idle.
module thick_styled_line_rasterizer import tslr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic        algorithm,
  input  logic [11:0] x_begin,
  input  logic [11:0] y_begin,
  input  logic [11:0] x_end,
  input  logic [11:0] y_end,
  input  logic [4:0]  pen_width,
  input  logic [1:0]  line_style,
  input  logic [23:0] pen_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] pixel_x,
  output logic [10:0] pixel_y,
  output logic [21:0] pixel_address,
  output logic [23:0] pixel_color,
  output logic        write_enable,
  output logic        last_of_span,
  output logic        line_done
);

  logic [11:0] frame_width, frame_height;
  logic        push, push_ready, pop, pop_valid;
  job_t        push_job, pop_job;

  // frame size registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 12'd640;
      frame_height <= 12'd480;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FRAME_WIDTH) frame_width <= cfg_data;
      else if (cfg_index == CFG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  tslr_front u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .algorithm,
    .x_begin, .y_begin, .x_end, .y_end, .pen_width, .line_style, .pen_color,
    .push, .push_job, .push_ready
  );

  tslr_queue u_queue (
    .clk, .rst, .push, .push_job, .push_ready, .pop, .pop_job, .pop_valid
  );

  tslr_back u_back (
    .clk, .rst, .frame_width, .frame_height, .pop_valid, .pop_job, .pop,
    .out_valid, .out_stall, .pixel_x, .pixel_y, .pixel_address, .pixel_color,
    .write_enable, .last_of_span, .line_done
  );

endmodule

// ----- src/tslr_front.sv -----
// command front end: latches a line, runs the decision rule, queues pen positions
// depends on tslr_pkg
module tslr_front import tslr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic              algorithm,
  input  logic [11:0]       x_begin,
  input  logic [11:0]       y_begin,
  input  logic [11:0]       x_end,
  input  logic [11:0]       y_end,
  input  logic [4:0]        pen_width,
  input  logic [1:0]        line_style,
  input  logic [23:0]       pen_color,
  output logic              push,
  output job_t              push_job,
  input  logic              push_ready
);

  phase_t             draw_phase;
  logic signed [13:0] major_pos, minor_pos, major_end;
  logic signed [15:0] decision_error;
  logic [11:0]        major_delta, minor_delta;
  logic               minor_step_down, steep_flag, alg;
  logic [3:0]         pattern_index;
  logic [4:0]         held_pen;
  logic [1:0]         held_style;
  logic [23:0]        held_color;

  logic accept;
  assign in_stall = !push_ready;
  assign accept = in_valid && push_ready;

  // start: axis swap, endpoint ordering, initial error and pen width clamp
  logic signed [12:0] dx13, dy13, adx, ady, md13, mm13;
  logic signed [11:0] ab, mb, ae, me, sb_maj, sb_mnr, se_maj, se_mnr;
  logic               steep_c, down_c;
  logic [11:0]        maj_d_c, mnr_d_c;
  logic [4:0]         pen_c;
  logic signed [15:0] err_c;
  logic signed [13:0] end_c;

  always_comb begin
    dx13 = 13'($signed(x_end)) - 13'($signed(x_begin));
    dy13 = 13'($signed(y_end)) - 13'($signed(y_begin));
    adx = dx13 < 0 ? -dx13 : dx13;
    ady = dy13 < 0 ? -dy13 : dy13;
    steep_c = adx < ady;
    ab = steep_c ? $signed(y_begin) : $signed(x_begin);
    mb = steep_c ? $signed(x_begin) : $signed(y_begin);
    ae = steep_c ? $signed(y_end) : $signed(x_end);
    me = steep_c ? $signed(x_end) : $signed(y_end);
    if (ae < ab) begin
      sb_maj = ae; sb_mnr = me; se_maj = ab; se_mnr = mb;
    end else begin
      sb_maj = ab; sb_mnr = mb; se_maj = ae; se_mnr = me;
    end
    md13 = 13'(se_maj) - 13'(sb_maj);
    mm13 = 13'(se_mnr) - 13'(sb_mnr);
    maj_d_c = md13[11:0];
    mnr_d_c = mm13 < 0 ? 12'(-mm13) : mm13[11:0];
    down_c = !(se_mnr > sb_mnr);
    if (algorithm == ALG_MIDPOINT) begin
      err_c = $signed({4'b0, maj_d_c}) - $signed({3'b0, mnr_d_c, 1'b0});
      end_c = 14'(se_maj);
    end else begin
      err_c = -$signed({4'b0, maj_d_c});
      end_c = 14'(se_maj) - 14'sd1;
    end
    if (line_style != 2'd0) pen_c = 5'd2;
    else if (pen_width == 5'd0) pen_c = 5'd1;
    else if (pen_width > 5'(MAX_PEN)) pen_c = 5'(MAX_PEN);
    else pen_c = pen_width;
  end

  // one step of the decision rule
  logic signed [13:0] pos_inc, mnr_step;
  logic signed [15:0] err_step, e2;
  always_comb begin
    pos_inc = major_pos + 14'sd1;
    mnr_step = minor_pos;
    e2 = '0;
    if (alg == ALG_MIDPOINT) begin
      if (decision_error < 0) begin
        mnr_step = minor_step_down ? minor_pos - 14'sd1 : minor_pos + 14'sd1;
        err_step = decision_error + $signed({3'b0, major_delta, 1'b0})
                   - $signed({3'b0, minor_delta, 1'b0});
      end else begin
        err_step = decision_error - $signed({3'b0, minor_delta, 1'b0});
      end
    end else begin
      e2 = decision_error + $signed({3'b0, minor_delta, 1'b0});
      if (e2 > 0) begin
        mnr_step = minor_step_down ? minor_pos - 14'sd1 : minor_pos + 14'sd1;
        err_step = e2 - $signed({3'b0, major_delta, 1'b0});
      end else begin
        err_step = e2;
      end
    end
  end

  // position job for the current phase
  always_comb begin
    push_job.mnr = minor_pos;
    push_job.steep = steep_flag;
    push_job.color = held_color;
    push_job.bit_on = dash_bit(held_style, pattern_index);
    push_job.done = 1'b0;
    push_job.maj = major_pos;
    push_job.w = held_pen;
    unique case (draw_phase)
      PH_START: begin
        push_job.maj = major_pos - 14'sd1;
        push_job.w = {1'b0, held_pen[4:1]};
      end
      PH_END: begin
        push_job.maj = (alg == ALG_MIDPOINT) ? pos_inc : major_pos;
        push_job.w = {1'b0, held_pen[4:1]};
        push_job.done = 1'b1;
      end
      default: ;
    endcase
  end

  assign push = accept && command == CMD_ADVANCE && draw_phase != PH_IDLE;

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_phase <= PH_IDLE;
      major_pos <= '0; minor_pos <= '0; major_end <= '0; decision_error <= '0;
      major_delta <= '0; minor_delta <= '0; minor_step_down <= 1'b0;
      steep_flag <= 1'b0; alg <= 1'b0; pattern_index <= '0; held_pen <= 5'd1;
      held_style <= '0; held_color <= '0;
    end else if (accept && command == CMD_START) begin
      draw_phase <= PH_START;
      major_pos <= 14'(sb_maj);
      minor_pos <= 14'(sb_mnr);
      major_end <= end_c;
      decision_error <= err_c;
      major_delta <= maj_d_c;
      minor_delta <= mnr_d_c;
      minor_step_down <= down_c;
      steep_flag <= steep_c;
      alg <= algorithm;
      pattern_index <= '0;
      held_pen <= pen_c;
      held_style <= line_style;
      held_color <= pen_color;
    end else if (push) begin
      pattern_index <= pattern_index + 4'd1;
      unique case (draw_phase)
        PH_START: begin
          draw_phase <= (major_pos < major_end || alg == ALG_MIDPOINT) ? PH_BODY : PH_END;
        end
        PH_BODY: begin
          if (alg == ALG_MIDPOINT) begin
            if (major_pos < major_end) begin
              major_pos <= pos_inc; minor_pos <= mnr_step; decision_error <= err_step;
            end else begin
              draw_phase <= PH_END;
            end
          end else begin
            major_pos <= pos_inc; minor_pos <= mnr_step; decision_error <= err_step;
            if (pos_inc >= major_end) draw_phase <= PH_END;
          end
        end
        default: draw_phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ----- src/tslr_queue.sv -----
// two-entry queue of pen positions between the front end and the span unit
// depends on tslr_pkg
module tslr_queue import tslr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output job_t pop_job,
  output logic pop_valid
);

  job_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign push_ready = count != 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_job = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/tslr_back.sv -----
// span unit: clips one pen position and, while out_stall is low, writes its pixels one per cycle
// depends on tslr_pkg
module tslr_back import tslr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] frame_width,
  input  logic [11:0] frame_height,
  input  logic        pop_valid,
  input  job_t        pop_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] pixel_x,
  output logic [10:0] pixel_y,
  output logic [21:0] pixel_address,
  output logic [23:0] pixel_color,
  output logic        write_enable,
  output logic        last_of_span,
  output logic        line_done
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SETUP = 4'b0010,
    B_ADDR  = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_t;

  bstate_t     state;
  job_t        job;
  logic [11:0] cur, hi_r, sx_r, sy_r;
  logic        wr;
  logic [21:0] addr;

  // frame test and span clipping
  logic signed [13:0] sx, sy;
  logic signed [14:0] lo, hi, lo_c, hi_c, dim;
  logic               onframe;
  always_comb begin
    sx = job.steep ? job.mnr : job.maj;
    sy = job.steep ? job.maj : job.mnr;
    onframe = sx >= 0 && sy >= 0 && sx < $signed({2'b0, frame_width})
              && sy < $signed({2'b0, frame_height});
    dim = job.steep ? $signed({3'b0, frame_width}) : $signed({3'b0, frame_height});
    lo = 15'(job.mnr) - $signed({11'b0, job.w[4:1]});
    hi = lo + $signed({10'b0, job.w});
    lo_c = lo < 0 ? 15'sd0 : lo;
    hi_c = hi > dim ? dim : hi;
  end

  // start address of the span
  logic [11:0] row, col;
  logic [23:0] prod;
  always_comb begin
    row = job.steep ? sy_r : cur;
    col = job.steep ? cur : sx_r;
    prod = row * frame_width;
  end

  logic out_free, last;
  assign out_free = !out_valid || !out_stall;
  assign last = (cur + 12'd1) == hi_r;
  assign pop = state == B_IDLE && pop_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == B_EMIT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (pop_valid) state <= B_SETUP;
        B_SETUP: state <= B_ADDR;
        B_ADDR: state <= B_EMIT;
        B_EMIT: begin
          if (out_free && (!wr || last)) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // span datapath and result register
  always_ff @(posedge clk) begin
    if (pop) job <= pop_job;
    if (state == B_SETUP) begin
      wr <= job.bit_on && onframe && lo_c < hi_c;
      cur <= lo_c[11:0];
      hi_r <= hi_c[11:0];
      sx_r <= sx[11:0];
      sy_r <= sy[11:0];
    end
    if (state == B_ADDR) addr <= prod[21:0] + {10'b0, col};
    if (state == B_EMIT && out_free) begin
      line_done <= job.done;
      if (!wr) begin
        pixel_x <= '0; pixel_y <= '0; pixel_address <= '0; pixel_color <= '0;
        write_enable <= 1'b0; last_of_span <= 1'b1;
      end else begin
        pixel_x <= job.steep ? cur[10:0] : sx_r[10:0];
        pixel_y <= job.steep ? sy_r[10:0] : cur[10:0];
        pixel_address <= addr;
        pixel_color <= job.color;
        write_enable <= 1'b1;
        last_of_span <= last;
        cur <= cur + 12'd1;
        addr <= addr + (job.steep ? 22'd1 : {10'b0, frame_width});
      end
    end
  end

endmodule

// ----- bench/tslr_checker.sv -----
// transaction checker for the thick styled line rasterizer: predicts pixel writes
// from accepted commands and compares them with the result channel
// depends on tslr_pkg
module tslr_checker import tslr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic        algorithm,
  input  logic [11:0] x_begin,
  input  logic [11:0] y_begin,
  input  logic [11:0] x_end,
  input  logic [11:0] y_end,
  input  logic [4:0]  pen_width,
  input  logic [1:0]  line_style,
  input  logic [23:0] pen_color,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [10:0] pixel_x,
  input  logic [10:0] pixel_y,
  input  logic [21:0] pixel_address,
  input  logic [23:0] pixel_color,
  input  logic        write_enable,
  input  logic        last_of_span,
  input  logic        line_done,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [21:0] addr;
    logic [23:0] color;
    logic        we;
    logic        last;
    logic        done;
  } pixel_t;

  // dash patterns, step 0 on the left
  localparam logic [0:15] DASH [4] = '{16'hFFFF, 16'b1111_0000_1111_0000,
                                       16'b1111_1111_1100_1100, 16'b1111_1100_1100_1100};

  pixel_t pixel_q[$];

  // line state
  int unsigned fw, fh;
  int          maj_pos, mnr_pos, maj_end, err, maj_delta, mnr_delta;
  bit          step_down, steep, alg_bres;
  phase_t      phase;
  int unsigned pidx, pen;
  logic [1:0]  style;
  logic [23:0] color;

  assign pending = pixel_q.size();

  // place one pen position and queue its pixel writes
  task automatic place_span(input int maj, input int mnr, input int unsigned w, input bit done);
    int     sx, sy, dim, lo, hi, n;
    bit     on;
    pixel_t p;
    n = 0;
    on = DASH[style][pidx];
    pidx = (pidx + 1) % 16;
    if (on) begin
      sx = steep ? mnr : maj;
      sy = steep ? maj : mnr;
      if (sx >= 0 && sy >= 0 && sx < int'(fw) && sy < int'(fh)) begin
        dim = steep ? int'(fw) : int'(fh);
        lo = mnr - int'(w / 2);
        hi = lo + int'(w);
        if (lo < 0) lo = 0;
        if (hi > dim) hi = dim;
        for (int i = lo; i < hi && n < 16; i++) begin
          p.x = steep ? i[10:0] : sx[10:0];
          p.y = steep ? sy[10:0] : i[10:0];
          p.addr = 22'((longint'(steep ? sy : i)) * fw + (steep ? i : sx));
          p.color = color;
          p.we = 1'b1;
          p.last = 1'b0;
          p.done = done;
          pixel_q.push_back(p);
          n++;
        end
      end
    end
    if (n == 0) begin
      p = '0;
      p.done = done;
      pixel_q.push_back(p);
    end
    pixel_q[pixel_q.size() - 1].last = 1'b1;
  endtask

  // one step along the major axis
  task automatic advance_major();
    int d;
    d = step_down ? -1 : 1;
    maj_pos++;
    if (!alg_bres) begin
      if (err < 0) begin
        mnr_pos += d;
        err += 2 * (maj_delta - mnr_delta);
      end else begin
        err -= 2 * mnr_delta;
      end
    end else begin
      err += 2 * mnr_delta;
      if (err > 0) begin
        mnr_pos += d;
        err -= 2 * maj_delta;
      end
    end
  endtask

  // latch a new line
  task automatic load_line();
    int xb, yb, xe, ye, adx, ady, t;
    xb = int'($signed(x_begin));
    yb = int'($signed(y_begin));
    xe = int'($signed(x_end));
    ye = int'($signed(y_end));
    pen = {27'b0, pen_width};
    if (line_style != 2'd0) pen = 2;
    if (pen < 1) pen = 1;
    if (pen > MAX_PEN) pen = MAX_PEN;
    adx = xe > xb ? xe - xb : xb - xe;
    ady = ye > yb ? ye - yb : yb - ye;
    steep = adx < ady;
    if (steep) begin
      t = xb; xb = yb; yb = t;
      t = xe; xe = ye; ye = t;
    end
    if (xe < xb) begin
      t = xb; xb = xe; xe = t;
      t = yb; yb = ye; ye = t;
    end
    maj_pos = xb;
    mnr_pos = yb;
    maj_delta = xe - xb;
    mnr_delta = ye > yb ? ye - yb : yb - ye;
    step_down = !(ye > yb);
    alg_bres = (algorithm == ALG_BRESENHAM);
    if (!alg_bres) begin
      maj_end = xe;
      err = maj_delta - 2 * mnr_delta;
    end else begin
      maj_end = xe - 1;
      err = -maj_delta;
    end
    style = line_style;
    color = pen_color;
    pidx = 0;
    phase = PH_START;
  endtask

  // advance one pen position
  task automatic next_position();
    case (phase)
      PH_START: begin
        place_span(maj_pos - 1, mnr_pos, pen / 2, 1'b0);
        phase = (maj_pos < maj_end || !alg_bres) ? PH_BODY : PH_END;
      end
      PH_BODY: begin
        place_span(maj_pos, mnr_pos, pen, 1'b0);
        if (!alg_bres) begin
          if (maj_pos < maj_end) advance_major();
          else phase = PH_END;
        end else begin
          advance_major();
          if (maj_pos >= maj_end) phase = PH_END;
        end
      end
      PH_END: begin
        phase = PH_IDLE;
        place_span(alg_bres ? maj_pos : maj_pos + 1, mnr_pos, pen / 2, 1'b1);
      end
      default: ;
    endcase
  endtask

  // watch all three channels
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      fw = 640; fh = 480;
      maj_pos = 0; mnr_pos = 0; maj_end = 0; err = 0; maj_delta = 0; mnr_delta = 0;
      step_down = 1'b0; steep = 1'b0; alg_bres = 1'b0; phase = PH_IDLE;
      pidx = 0; pen = 1; style = '0; color = '0;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) fw = {20'b0, cfg_data};
        else if (cfg_index == CFG_FRAME_HEIGHT) fh = {20'b0, cfg_data};
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("pixel write with no expectation: x %0d y %0d", pixel_x, pixel_y);
          fail_count++;
        end else begin
          e = pixel_q.pop_front();
          if (pixel_x !== e.x) begin
            $error("pixel_x expected %0d got %0d", e.x, pixel_x); fail_count++;
          end
          if (pixel_y !== e.y) begin
            $error("pixel_y expected %0d got %0d", e.y, pixel_y); fail_count++;
          end
          if (pixel_address !== e.addr) begin
            $error("pixel_address expected %0d got %0d", e.addr, pixel_address); fail_count++;
          end
          if (pixel_color !== e.color) begin
            $error("pixel_color expected %h got %h", e.color, pixel_color); fail_count++;
          end
          if (write_enable !== e.we) begin
            $error("write_enable expected %0d got %0d", e.we, write_enable); fail_count++;
          end
          if (last_of_span !== e.last) begin
            $error("last_of_span expected %0d got %0d", e.last, last_of_span); fail_count++;
          end
          if (line_done !== e.done) begin
            $error("line_done expected %0d got %0d", e.done, line_done); fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_START) load_line();
        else next_position();
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
// top of the line rasterizer bench: clock, reset, command and register stimulus,
// result-side backpressure, watchdog and verdict
// depends on tslr_pkg, thick_styled_line_rasterizer and tslr_checker
module testbench;
  import tslr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = CMD_ADVANCE;
  logic        algorithm = ALG_MIDPOINT;
  logic [11:0] x_begin = '0, y_begin = '0, x_end = '0, y_end = '0;
  logic [4:0]  pen_width = '0;
  logic [1:0]  line_style = '0;
  logic [23:0] pen_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] pixel_x, pixel_y;
  logic [21:0] pixel_address;
  logic [23:0] pixel_color;
  logic        write_enable, last_of_span, line_done;
  int          fail_count, pending;

  bit no_idle = 0;
  bit hold_request = 0;
  int idle_cycles = 0;
  int sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  thick_styled_line_rasterizer i_dut (.*);
  tslr_checker i_checker (.*);

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // result-side backpressure, with one long hold-off on request
  always begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    n = no_idle ? 0 : $urandom_range(0, 14);
    if (hold_request) begin
      n = 300;
      hold_request = 0;
    end
    if (n != 0) begin
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
      out_stall <= 1'b0;
    end
    do @(posedge clk); while (!out_valid);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected pixel has come, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send(input logic cmd, input logic alg, input logic [11:0] xb, input logic [11:0] yb,
                      input logic [11:0] xe, input logic [11:0] ye, input logic [4:0] pw,
                      input logic [1:0] sty, input logic [23:0] col);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd; algorithm <= alg;
    x_begin <= xb; y_begin <= yb; x_end <= xe; y_end <= ye;
    pen_width <= pw; line_style <= sty; pen_color <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic advances(input int n);
    repeat (n) send(CMD_ADVANCE, 1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                    12'($urandom), 12'($urandom), 5'($urandom), 2'($urandom),
                    24'($urandom));
  endtask

  // start a line and walk it to the end (or part way for a broken line)
  task automatic line(input logic alg, input int xb, input int yb, input int xe, input int ye,
                      input logic [4:0] pw, input logic [1:0] sty, input logic [23:0] col,
                      input int steps);
    send(CMD_START, alg, xb[11:0], yb[11:0], xe[11:0], ye[11:0], pw, sty, col);
    advances(steps);
  endtask

  function automatic int span_of(input int xb, input int yb, input int xe, input int ye);
    int dx, dy;
    dx = xe > xb ? xe - xb : xb - xe;
    dy = ye > yb ? ye - yb : yb - ye;
    return (dx > dy ? dx : dy) + 3;
  endfunction

  // random line, mostly short and near the visible frame
  task automatic random_line(input int fw, input int fh);
    int xb, yb, xe, ye, steps, pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // full-range coordinates, cut short
      line(1'($urandom), $urandom, $urandom, $urandom, $urandom, 5'($urandom), 2'($urandom),
           24'($urandom), $urandom_range(1, 4));
    end else begin
      xb = $urandom_range(0, (fw > 60 ? 60 : fw) + 8) - 4;
      yb = $urandom_range(0, (fh > 60 ? 60 : fh) + 8) - 4;
      xe = xb + $urandom_range(0, 24) - 12;
      ye = yb + $urandom_range(0, 24) - 12;
      steps = span_of(xb, yb, xe, ye);
      if (pick == 1) steps = $urandom_range(0, steps);
      else steps += $urandom_range(0, 1);
      line(1'($urandom), xb, yb, xe, ye, 5'($urandom),
           $urandom_range(0, 3) == 0 ? 2'($urandom) : 2'd0, 24'($urandom), steps);
    end
  endtask

  int fw_set[8] = '{640, 1, 16, 0, 4095, 2047, 100, 37};
  int fh_set[8] = '{480, 1, 12, 480, 4095, 2047, 0, 23};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines at the default frame size
    advances(1);
    line(ALG_MIDPOINT, 2, 5, 5, 5, 5'd16, 2'd0, 24'hFFFFFF, 7);
    line(ALG_BRESENHAM, 9, 1, 4, 9, 5'd31, 2'd0, 24'h000000, 9);
    line(ALG_MIDPOINT, 3, 3, 3, 3, 5'd0, 2'd1, 24'h123456, 3);
    line(ALG_BRESENHAM, 3, 3, 3, 3, 5'd1, 2'd2, 24'hABCDEF, 3);
    line(ALG_MIDPOINT, -2048, 2047, 2047, -2048, 5'd7, 2'd3, 24'h800001, 2);
    drain();

    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      write_reg(CFG_FRAME_WIDTH, fw_set[phase_no][11:0]);
      write_reg(CFG_FRAME_HEIGHT, fh_set[phase_no][11:0]);
      no_idle = (phase_no == 2);
      if (phase_no == 1) hold_request = 1;
      while (sent < 50 * (phase_no + 1) + 10)
        random_line(fw_set[phase_no], fh_set[phase_no]);
      drain();
    end
    write_reg(CFG_FRAME_WIDTH, 12'd640);
    write_reg(CFG_FRAME_HEIGHT, 12'd480);
    repeat (4) random_line(640, 480);
    drain();

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
